// ===== rtl/core/dsmcc_pkg.sv =====
// Package for the DSM-CC DII/DDB section parser: phases, item types, field sizes.
// No dependencies.
`default_nettype none
package dsmcc_pkg;

  localparam logic [7:0] TID_DII = 8'h3b;
  localparam logic [7:0] TID_DDB = 8'h3c;

  localparam logic [4:0] PH_ADAPT   = 5'd25;
  localparam logic [4:0] PH_COMPAT  = 5'd26;
  localparam logic [4:0] PH_MODINFO = 5'd27;
  localparam logic [4:0] PH_PRIV    = 5'd28;
  localparam logic [4:0] PH_BLOCK   = 5'd29;
  localparam logic [4:0] PH_DONE    = 5'd30;
  localparam logic [4:0] PH_IDLE    = 5'd31;

  localparam logic [4:0] FC_ADAPT_LEN  = 5'd5;
  localparam logic [4:0] FC_MSG_LEN    = 5'd6;
  localparam logic [4:0] FC_ADAPT_TYPE = 5'd7;
  localparam logic [4:0] FC_DII_FIRST  = 5'd8;
  localparam logic [4:0] FC_COMPAT_LEN = 5'd14;
  localparam logic [4:0] FC_NUM_MODS   = 5'd15;
  localparam logic [4:0] FC_MOD_ID     = 5'd16;
  localparam logic [4:0] FC_MOD_INFO_L = 5'd19;
  localparam logic [4:0] FC_PRIV_LEN   = 5'd20;
  localparam logic [4:0] FC_DDB_FIRST  = 5'd21;
  localparam logic [4:0] FC_BLOCK_NUM  = 5'd24;

  typedef enum logic [1:0] {
    MK_NONE = 2'd0, MK_DII = 2'd1, MK_DDB = 2'd2, MK_UNSUP = 2'd3
  } msg_kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_LEN_MISMATCH = 2'd1, ST_NEG_BLOCK = 2'd2, ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PK_ADAPT = 2'd0, PK_MODINFO = 2'd1, PK_PRIV = 2'd2, PK_BLOCK = 2'd3
  } pay_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] sect_tid;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        field_done;
    logic [4:0]  field_code;
    logic [31:0] field_value;
    logic        payload_valid;
    logic [1:0]  payload_kind;
    logic [7:0]  payload_byte;
    logic [15:0] module_index;
    logic        section_end;
    logic [1:0]  status;
  } out_item_t;

  function automatic logic [2:0] field_size(input logic [4:0] code);
    logic [2:0] s;
    unique case (code)
      5'd2, 5'd6, 5'd9, 5'd14, 5'd15, 5'd16, 5'd20, 5'd21, 5'd24: s = 3'd2;
      5'd3, 5'd8, 5'd12, 5'd13, 5'd17: s = 3'd4;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dsmcc_if.sv =====
// Valid/ready channel interface carrying one item per handshake.
// Depends on dsmcc_pkg for the item types.
`default_nettype none
interface dsmcc_in_if import dsmcc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dsmcc_out_if import dsmcc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dsmcc_front.sv =====
// Front part: accepts section bytes and marks bytes outside any section.
// Depends on dsmcc_pkg; feeds dsmcc_queue.
`default_nettype none
module dsmcc_front import dsmcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  dsmcc_in_if.sink  in_ch,
  output logic      push,
  output in_item_t  push_item,
  output logic      drop_zero,
  input  wire logic q_full
);
  logic in_sec_r, in_sec_nxt;
  logic acc;

  // Bytes outside a section still produce an all-zero word, so they are forwarded
  // with a marker instead of being dropped.
  assign in_ch.ready = !q_full;
  assign acc       = in_ch.valid && in_ch.ready;
  assign push      = acc;
  assign push_item = in_ch.data;
  assign drop_zero = !in_ch.data.first_byte && !in_sec_r;

  always_comb begin
    in_sec_nxt = in_sec_r;
    if (acc) begin
      if (in_ch.data.first_byte) in_sec_nxt = 1'b1;
      if (in_ch.data.last_byte && (in_ch.data.first_byte || in_sec_r)) in_sec_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_sec_r <= 1'b0;
    else in_sec_r <= in_sec_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/dsmcc_queue.sv =====
// Two-entry queue between the front and the back parts.
// Depends on dsmcc_pkg.
`default_nettype none
module dsmcc_queue import dsmcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  in_item_t  push_item,
  input  wire logic push_zero,
  output logic      full,
  output logic      not_empty,
  output in_item_t  head_item,
  output logic      head_zero,
  input  wire logic pop
);
  in_item_t   item_r [2];
  logic [1:0] zero_r;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head_item = item_r[rp_r];
  assign head_zero = zero_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wp_r] <= push_item;
      zero_r[wp_r] <= push_zero;
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dsmcc_back.sv =====
// Back part: phase machine that assembles fields and tags payload, with an
// output register. Depends on dsmcc_pkg.
`default_nettype none
module dsmcc_back import dsmcc_pkg::*; #(
  parameter int DDB_FIXED = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  avail,
  input  in_item_t   item,
  input  wire logic  item_zero,
  output logic       pop,
  dsmcc_out_if.source out_ch
);
  logic [4:0]  phase_r, phase_nxt;
  msg_kind_t   kind_r, kind_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] span_r, span_nxt, mleft_r, mleft_nxt, mctr_r, mctr_nxt, mlen_r, mlen_nxt;
  logic [7:0]  alen_r, alen_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        ov_r;
  out_item_t   o_r, o;
  logic        step;
  logic [4:0]  ph, nf;
  logic [31:0] v;
  logic [2:0]  cinc;
  logic [16:0] blen;
  logic [15:0] sdec;

  assign step = avail && (!ov_r || out_ch.ready);
  assign pop  = step;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = o_r;

  always_comb begin
    phase_nxt = phase_r; kind_nxt = kind_r; cnt_nxt = cnt_r; acc_nxt = acc_r;
    span_nxt = span_r; mleft_nxt = mleft_r; mctr_nxt = mctr_r; mlen_nxt = mlen_r;
    alen_nxt = alen_r; err_nxt = err_r;
    o = '0; v = '0; nf = '0; cinc = '0; ph = '0;
    blen = {1'b0, mlen_r} - {9'd0, alen_r} - 17'(DDB_FIXED);
    sdec = span_r - 16'd1;
    if (!item_zero) begin
      if (item.first_byte) begin
        phase_nxt = 5'd0; cnt_nxt = '0; acc_nxt = '0; span_nxt = '0; mleft_nxt = '0;
        mctr_nxt = '0; mlen_nxt = '0; alen_nxt = '0; err_nxt = ST_OK;
        if (item.sect_tid == TID_DII) kind_nxt = MK_DII;
        else if (item.sect_tid == TID_DDB) kind_nxt = MK_DDB;
        else begin kind_nxt = MK_UNSUP; err_nxt = ST_UNSUPPORTED; end
      end
      ph = phase_nxt;
      if (err_nxt != ST_OK) begin
      end else if (ph <= FC_BLOCK_NUM) begin
        if (ph >= FC_MOD_ID && ph <= FC_MOD_INFO_L) o.module_index = mctr_nxt;
        v = {acc_nxt[23:0], item.data_byte};
        cinc = cnt_nxt + 3'd1;
        acc_nxt = v; cnt_nxt = cinc;
        if (cinc >= field_size(ph)) begin
          o.field_done = 1'b1; o.field_code = ph; o.field_value = v;
          acc_nxt = '0; cnt_nxt = '0;
          priority case (ph)
            FC_ADAPT_LEN: begin alen_nxt = v[7:0]; nf = FC_MSG_LEN; end
            FC_MSG_LEN: begin
              mlen_nxt = v[15:0];
              nf = (alen_nxt != 0) ? FC_ADAPT_TYPE
                 : ((kind_nxt == MK_DDB) ? FC_DDB_FIRST : FC_DII_FIRST);
            end
            FC_ADAPT_TYPE: begin
              span_nxt = {8'd0, alen_nxt - 8'd1};
              nf = (span_nxt != 0) ? PH_ADAPT
                 : ((kind_nxt == MK_DDB) ? FC_DDB_FIRST : FC_DII_FIRST);
            end
            FC_COMPAT_LEN: begin
              span_nxt = v[15:0]; nf = (span_nxt != 0) ? PH_COMPAT : FC_NUM_MODS;
            end
            FC_NUM_MODS: begin
              mleft_nxt = v[15:0]; mctr_nxt = '0;
              nf = (mleft_nxt != 0) ? FC_MOD_ID : FC_PRIV_LEN;
            end
            FC_MOD_INFO_L: begin
              span_nxt = {8'd0, v[7:0]};
              if (span_nxt != 0) nf = PH_MODINFO;
              else begin
                mleft_nxt = mleft_nxt - 16'd1; mctr_nxt = mctr_nxt + 16'd1;
                nf = (mleft_nxt != 0) ? FC_MOD_ID : FC_PRIV_LEN;
              end
            end
            FC_PRIV_LEN: begin
              span_nxt = v[15:0]; nf = (span_nxt != 0) ? PH_PRIV : PH_DONE;
            end
            FC_BLOCK_NUM: begin
              if (blen[16]) begin err_nxt = ST_NEG_BLOCK; nf = PH_DONE; end
              else begin span_nxt = blen[15:0]; nf = (span_nxt != 0) ? PH_BLOCK : PH_DONE; end
            end
            default: nf = ph + 5'd1;
          endcase
          phase_nxt = nf;
        end
      end else if (ph == PH_DONE) begin
        err_nxt = ST_LEN_MISMATCH;
      end else begin
        // span_r is zero after a new-section restart only in field phases,
        // so the registered span is valid here.
        span_nxt = sdec;
        if (ph != PH_COMPAT) begin o.payload_valid = 1'b1; o.payload_byte = item.data_byte; end
        unique case (ph)
          PH_ADAPT: begin
            o.payload_kind = PK_ADAPT;
            if (sdec == 0) phase_nxt = (kind_nxt == MK_DDB) ? FC_DDB_FIRST : FC_DII_FIRST;
          end
          PH_COMPAT: if (sdec == 0) phase_nxt = FC_NUM_MODS;
          PH_MODINFO: begin
            o.payload_kind = PK_MODINFO; o.module_index = mctr_nxt;
            if (sdec == 0) begin
              mleft_nxt = mleft_nxt - 16'd1; mctr_nxt = mctr_nxt + 16'd1;
              phase_nxt = (mleft_nxt != 0) ? FC_MOD_ID : FC_PRIV_LEN;
            end
          end
          PH_PRIV: begin
            o.payload_kind = PK_PRIV; if (sdec == 0) phase_nxt = PH_DONE;
          end
          default: begin
            o.payload_kind = PK_BLOCK; if (sdec == 0) phase_nxt = PH_DONE;
          end
        endcase
      end
      if (item.last_byte) begin
        o.section_end = 1'b1;
        o.status = (err_nxt != ST_OK) ? err_nxt
                 : ((phase_nxt == PH_DONE) ? ST_OK : ST_LEN_MISMATCH);
        phase_nxt = PH_IDLE; kind_nxt = MK_NONE; cnt_nxt = '0; acc_nxt = '0;
        span_nxt = '0; mleft_nxt = '0; mctr_nxt = '0; mlen_nxt = '0;
        alen_nxt = '0; err_nxt = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) o_r <= o;
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= MK_NONE; cnt_r <= '0; acc_r <= '0; span_r <= '0;
      mleft_r <= '0; mctr_r <= '0; mlen_r <= '0; alen_r <= '0; err_r <= ST_OK;
      ov_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; kind_r <= kind_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt;
        span_r <= span_nxt; mleft_r <= mleft_nxt; mctr_r <= mctr_nxt;
        mlen_r <= mlen_nxt; alen_r <= alen_nxt; err_r <= err_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dsmcc_dii_ddb_section_parser_unit.sv =====
// Top level of the DSM-CC DII/DDB section parser.
// Depends on dsmcc_pkg, dsmcc_if, dsmcc_front, dsmcc_queue and dsmcc_back.
//
//   channel | role   | word
//   in_ch   | sink   | data_byte, table_id, first_byte, last_byte
//   out_ch  | source | field, payload, module index and section status
//
// One word is taken per cycle and one result word leaves per cycle while out_ch
// is ready; the phase machine handles each byte as it leaves the queue.
// A word passes through the two-entry queue and then the output register.
// Reset is synchronous and active low; it returns the parser to idle.
// A stalled output fills the queue, and only then is in_ch.ready dropped.
`default_nettype none
module dsmcc_dii_ddb_section_parser_unit import dsmcc_pkg::*; #(
  parameter int DDB_FIXED_BYTES = 6
) (
  input wire logic     clk,
  input wire logic     rst_n,
  dsmcc_in_if.sink     in_ch,
  dsmcc_out_if.source  out_ch
);
  logic     push, push_zero, q_full, q_ne, q_zero, pop;
  in_item_t push_item, head_item;

  // The front marks bytes that fall outside a section; they still yield a zero word.
  dsmcc_front u_front (
    .clk, .rst_n, .in_ch, .push, .push_item, .drop_zero(push_zero), .q_full
  );

  // The queue lets the front keep taking bytes while the back waits on out_ch.
  dsmcc_queue u_queue (
    .clk, .rst_n, .push, .push_item, .push_zero, .full(q_full), .not_empty(q_ne),
    .head_item, .head_zero(q_zero), .pop
  );

  // The back runs the phase machine and holds the result in its output register.
  dsmcc_back #(.DDB_FIXED(DDB_FIXED_BYTES)) u_back (
    .clk, .rst_n, .avail(q_ne), .item(head_item), .item_zero(q_zero), .pop, .out_ch
  );
endmodule
`default_nettype wire

// ===== rtl/core/dsmcc_checker.sv =====
// Port checker for the section parser, bound to the top level.
// Depends on dsmcc_pkg.
`default_nettype none
module dsmcc_checker import dsmcc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      ov,
  input wire logic      ordy,
  input out_item_t      od
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov && !ordy |=> ov && $stable(od)) else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ov |-> !(od.field_done && od.payload_valid)) else $error("field and payload together");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    ov && !od.section_end |-> od.status == ST_OK) else $error("status without section end");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov && od.field_done |-> od.field_code <= FC_BLOCK_NUM) else $error("bad field code");
endmodule

bind dsmcc_dii_ddb_section_parser_unit dsmcc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .ov(out_ch.valid), .ordy(out_ch.ready), .od(out_ch.data)
);
`default_nettype wire

// ===== sim/tb_dsmcc_scoreboard.sv =====
// Scoreboard for the DSM-CC DII/DDB section parser: a byte-level parse predictor
// and a queue of expected result words. Depends on dsmcc_pkg.
`default_nettype none
package tb_dsmcc_sb_pkg;
  import dsmcc_pkg::*;

  class dsmcc_parse_scoreboard;
    logic [4:0]  phase;
    msg_kind_t   kind;
    logic [2:0]  byte_cnt;
    logic [31:0] acc;
    logic [15:0] span_left;
    logic [15:0] mods_left;
    logic [15:0] mod_idx;
    logic [15:0] msg_len;
    logic [7:0]  adapt_len;
    status_t     err;
    out_item_t   expected_words[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_IDLE;
      kind = MK_NONE;
      byte_cnt = '0;
      acc = '0;
      span_left = '0;
      mods_left = '0;
      mod_idx = '0;
      msg_len = '0;
      adapt_len = '0;
      err = ST_OK;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [2:0] bytes_of(logic [4:0] code);
      case (code)
        5'd2, 5'd6, 5'd9, 5'd14, 5'd15, 5'd16, 5'd20, 5'd21, 5'd24: return 3'd2;
        5'd3, 5'd8, 5'd12, 5'd13, 5'd17: return 3'd4;
        default: return 3'd1;
      endcase
    endfunction

    function logic [4:0] header_exit();
      return (kind == MK_DDB) ? FC_DDB_FIRST : FC_DII_FIRST;
    endfunction

    function logic [4:0] module_done();
      mods_left = mods_left - 16'd1;
      mod_idx = mod_idx + 16'd1;
      return (mods_left != 0) ? FC_MOD_ID : FC_PRIV_LEN;
    endfunction

    function logic [4:0] phase_after(logic [4:0] code, logic [31:0] v);
      int blen;
      case (code)
        FC_ADAPT_LEN: begin
          adapt_len = v[7:0];
          return FC_MSG_LEN;
        end
        FC_MSG_LEN: begin
          msg_len = v[15:0];
          return (adapt_len != 0) ? FC_ADAPT_TYPE : header_exit();
        end
        FC_ADAPT_TYPE: begin
          span_left = {8'd0, adapt_len} - 16'd1;
          return (span_left != 0) ? PH_ADAPT : header_exit();
        end
        FC_COMPAT_LEN: begin
          span_left = v[15:0];
          return (span_left != 0) ? PH_COMPAT : FC_NUM_MODS;
        end
        FC_NUM_MODS: begin
          mods_left = v[15:0];
          mod_idx = '0;
          return (mods_left != 0) ? FC_MOD_ID : FC_PRIV_LEN;
        end
        FC_MOD_INFO_L: begin
          span_left = {8'd0, v[7:0]};
          return (span_left != 0) ? PH_MODINFO : module_done();
        end
        FC_PRIV_LEN: begin
          span_left = v[15:0];
          return (span_left != 0) ? PH_PRIV : PH_DONE;
        end
        FC_BLOCK_NUM: begin
          blen = int'(msg_len) - int'(adapt_len) - 6;
          if (blen < 0) begin
            err = ST_NEG_BLOCK;
            return PH_DONE;
          end
          span_left = blen[15:0];
          return (span_left != 0) ? PH_BLOCK : PH_DONE;
        end
        default: return code + 5'd1;
      endcase
    endfunction

    // Notes one accepted input word and queues the result it produces.
    function void note_input(in_item_t w);
      out_item_t r;
      r = '0;
      if (w.first_byte) begin
        clear();
        phase = 5'd0;
        if (w.sect_tid == TID_DII) kind = MK_DII;
        else if (w.sect_tid == TID_DDB) kind = MK_DDB;
        else begin
          kind = MK_UNSUP;
          err = ST_UNSUPPORTED;
        end
      end else if (phase == PH_IDLE) begin
        expected_words = {expected_words, r};
        return;
      end
      if (err != ST_OK) begin
      end else if (phase <= 5'd24) begin
        if (phase >= FC_MOD_ID && phase <= FC_MOD_INFO_L) r.module_index = mod_idx;
        acc = {acc[23:0], w.data_byte};
        byte_cnt = byte_cnt + 3'd1;
        if (byte_cnt >= bytes_of(phase)) begin
          r.field_done = 1'b1;
          r.field_code = phase;
          r.field_value = acc;
          phase = phase_after(phase, acc);
          byte_cnt = '0;
          acc = '0;
        end
      end else if (phase == PH_DONE) begin
        err = ST_LEN_MISMATCH;
      end else begin
        span_left = span_left - 16'd1;
        if (phase != PH_COMPAT) begin
          r.payload_valid = 1'b1;
          r.payload_byte = w.data_byte;
        end
        case (phase)
          PH_ADAPT: begin
            r.payload_kind = PK_ADAPT;
            if (span_left == 0) phase = header_exit();
          end
          PH_COMPAT: if (span_left == 0) phase = FC_NUM_MODS;
          PH_MODINFO: begin
            r.payload_kind = PK_MODINFO;
            r.module_index = mod_idx;
            if (span_left == 0) phase = module_done();
          end
          PH_PRIV: begin
            r.payload_kind = PK_PRIV;
            if (span_left == 0) phase = PH_DONE;
          end
          default: begin
            r.payload_kind = PK_BLOCK;
            if (span_left == 0) phase = PH_DONE;
          end
        endcase
      end
      if (w.last_byte) begin
        r.section_end = 1'b1;
        if (err != ST_OK) r.status = err;
        else r.status = (phase == PH_DONE) ? ST_OK : ST_LEN_MISMATCH;
        clear();
      end
      expected_words = {expected_words, r};
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", got);
        mismatches++;
        return;
      end
      e = expected_words.pop_front();
      if (got.field_done !== e.field_done) begin
        $error("field_done: expected %0d, got %0d", e.field_done, got.field_done);
        mismatches++;
      end
      if (got.field_code !== e.field_code) begin
        $error("field_code: expected %0d, got %0d", e.field_code, got.field_code);
        mismatches++;
      end
      if (got.field_value !== e.field_value) begin
        $error("field_value: expected %h, got %h", e.field_value, got.field_value);
        mismatches++;
      end
      if (got.payload_valid !== e.payload_valid) begin
        $error("payload_valid: expected %0d, got %0d", e.payload_valid, got.payload_valid);
        mismatches++;
      end
      if (got.payload_kind !== e.payload_kind) begin
        $error("payload_kind: expected %0d, got %0d", e.payload_kind, got.payload_kind);
        mismatches++;
      end
      if (got.payload_byte !== e.payload_byte) begin
        $error("payload_byte: expected %h, got %h", e.payload_byte, got.payload_byte);
        mismatches++;
      end
      if (got.module_index !== e.module_index) begin
        $error("module_index: expected %0d, got %0d", e.module_index, got.module_index);
        mismatches++;
      end
      if (got.section_end !== e.section_end) begin
        $error("section_end: expected %0d, got %0d", e.section_end, got.section_end);
        mismatches++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        mismatches++;
      end
    endfunction
  endclass
endpackage
`default_nettype wire

// ===== sim/tb_dsmcc_dii_ddb_section_parser_unit.sv =====
// Testbench top for dsmcc_dii_ddb_section_parser_unit: builds DII and DDB
// sections byte by byte and checks every result word against a scoreboard.
// Depends on dsmcc_pkg, dsmcc_if and tb_dsmcc_sb_pkg.
`default_nettype none
module tb_dsmcc_dii_ddb_section_parser_unit;
  import dsmcc_pkg::*;
  import tb_dsmcc_sb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  dsmcc_in_if  in_ch ();
  dsmcc_out_if out_ch ();

  dsmcc_dii_ddb_section_parser_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  dsmcc_parse_scoreboard sb = new();

  // Section bytes are staged in a queue before being sent; each entry keeps
  // its table id and the first and last markers.
  in_item_t byte_queue[$];
  int  words_in;
  bit  hold_off;     // the receiver is forced to stall while this is set
  int  idle_cycles;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_off = 1'b0;
    words_in = 0;
    idle_cycles = 0;
  end

  // Scoreboard updates happen on the edge that accepts a word, so the
  // predictor sees bytes in the same order the block does.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_input(in_ch.data);
      words_in++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Receiver: a stall pattern of its own, plus a forced long hold-off.
  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else begin
      case ($urandom_range(0, 3))
        0: out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // Watchdog on cycles in which nothing moves on either channel, outside the forced hold-off.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (!hold_off)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("** dsmcc_dii_ddb_section_parser_unit: FAILED **");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    in_item_t w;
    w = '0;
    w.data_byte = b;
    byte_queue = {byte_queue, w};
  endtask

  task automatic add_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  // Marks the section boundaries on the staged bytes, starting at index s.
  task automatic seal_section(input int s, input logic [7:0] tid);
    if (byte_queue.size() <= s) add_byte(8'($urandom));
    byte_queue[s].first_byte = 1'b1;
    byte_queue[s].sect_tid = tid;
    byte_queue[$].last_byte = 1'b1;
  endtask

  task automatic add_header(input logic [15:0] mlen, input logic [7:0] alen);
    add_field(32'($urandom), 1);
    add_field(32'($urandom), 1);
    add_field(32'($urandom), 2);
    add_field($urandom, 4);
    add_field(32'($urandom), 1);
    add_field({24'd0, alen}, 1);
    add_field({16'd0, mlen}, 2);
    for (int i = 0; i < alen; i++) add_byte(8'($urandom));
  endtask

  // A DII section; trim or extend by delta bytes to make it short or long.
  task automatic build_dii(input int nmods, input int compat, input int priv,
                           input int alen, input int delta);
    int s;
    s = byte_queue.size();
    add_header(16'($urandom), 8'(alen));
    add_field($urandom, 4);
    add_field(32'($urandom), 2);
    add_field(32'($urandom), 1);
    add_field(32'($urandom), 1);
    add_field($urandom, 4);
    add_field($urandom, 4);
    add_field(compat, 2);
    for (int i = 0; i < compat; i++) add_byte(8'($urandom));
    add_field(nmods, 2);
    for (int m = 0; m < nmods; m++) begin
      int ilen;
      ilen = $urandom_range(0, 4);
      add_field(32'($urandom), 2);
      add_field($urandom, 4);
      add_field(32'($urandom), 1);
      add_field(ilen, 1);
      for (int i = 0; i < ilen; i++) add_byte(8'($urandom));
    end
    add_field(priv, 2);
    for (int i = 0; i < priv; i++) add_byte(8'($urandom));
    for (int i = 0; i < delta; i++) add_byte(8'($urandom));
    for (int i = 0; i > delta && byte_queue.size() > s + 1; i--) void'(byte_queue.pop_back());
    seal_section(s, TID_DII);
  endtask

  // A DDB section; mlen may be chosen below the fixed part to go negative.
  task automatic build_ddb(input int blen, input int alen, input bit negative,
                           input int delta);
    int s;
    int mlen;
    s = byte_queue.size();
    mlen = negative ? $urandom_range(0, alen + 5) : blen + alen + 6;
    add_header(16'(mlen), 8'(alen));
    add_field(32'($urandom), 2);
    add_field(32'($urandom), 1);
    add_field(32'($urandom), 1);
    add_field(32'($urandom), 2);
    if (!negative) for (int i = 0; i < blen; i++) add_byte(8'($urandom));
    for (int i = 0; i < delta; i++) add_byte(8'($urandom));
    for (int i = 0; i > delta && byte_queue.size() > s + 1; i--) void'(byte_queue.pop_back());
    seal_section(s, TID_DDB);
  endtask

  // Sends everything staged, in bursts with random gaps if gaps is set; at most one
  // nonblocking assignment to valid per edge.
  task automatic send_staged(input bit gaps);
    int burst;
    burst = 0;
    while (byte_queue.size() != 0) begin
      if (gaps && burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 1)) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      in_ch.valid <= 1'b1;
      in_ch.data <= byte_queue.pop_front();
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      burst--;
      if (burst < 0) burst = 0;
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_noise(input int n);
    for (int i = 0; i < n; i++) begin
      in_item_t w;
      w.data_byte = 8'($urandom);
      w.sect_tid = 8'($urandom);
      w.first_byte = 1'($urandom);
      w.last_byte = 1'($urandom);
      if ($urandom_range(0, 1)) w.sect_tid = $urandom_range(0, 1) ? TID_DII : TID_DDB;
      byte_queue = {byte_queue, w};
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: stray bytes, a one-byte section, unsupported table,
    // zero-length spans, negative block length, short and long sections.
    begin
      in_item_t w;
      w = '0;
      w.data_byte = 8'hff;
      w.last_byte = 1'b1;
      byte_queue = {byte_queue, w};
      w.first_byte = 1'b1;
      w.sect_tid = TID_DII;
      byte_queue = {byte_queue, w};
      w.sect_tid = 8'hff;
      w.last_byte = 1'b0;
      w.data_byte = 8'h00;
      byte_queue = {byte_queue, w};
      w = '0;
      w.last_byte = 1'b1;
      byte_queue = {byte_queue, w};
    end
    send_staged(1'b0);
    build_dii(0, 0, 0, 0, 0);
    build_dii(2, 3, 2, 3, 0);
    build_ddb(0, 0, 1'b0, 0);
    build_ddb(3, 1, 1'b0, 0);
    build_ddb(0, 2, 1'b1, 2);
    build_ddb(2, 0, 1'b0, 2);
    build_dii(1, 0, 1, 1, -5);
    send_staged(1'b0);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering bytes.
    fork
      begin
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        build_ddb(8, 0, 1'b0, 0);
        send_staged(1'b0);
      end
    join
    wait_drained();

    // Random part: mostly well-formed sections, some broken, some noise.
    while (words_in < 440) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: build_dii($urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) - 3 : 0);
        4, 5, 6: build_ddb($urandom_range(0, 10), $urandom_range(0, 3), 1'b0,
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) - 3 : 0);
        7: build_ddb(0, $urandom_range(0, 3), 1'b1, 0);
        default: random_noise($urandom_range(1, 8));
      endcase
      send_staged(1'b1);
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** dsmcc_dii_ddb_section_parser_unit: PASSED **");
    else
      $display("** dsmcc_dii_ddb_section_parser_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
